/* hw/rtl/nrcc_pkg.sv */
package nrcc_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int FRAC_BITS = 4;
  localparam int FIELD_W = 16;
  localparam int REG_W = 64;
  localparam int IDX_W = 3;

  // Sum of four squared channel differences, then the radicand after the fraction shift.
  localparam int SUM_W = 2 * CHANNEL_BITS + 2;
  localparam int RAD_W = SUM_W + 2 * FRAC_BITS;
  localparam int ROOT_W = RAD_W / 2;
  localparam int MAG_W = (ROOT_W > FIELD_W) ? ROOT_W : FIELD_W;
  localparam int ADJ_W = MAG_W + 1;
  localparam int STEP_W = $clog2(ROOT_W);

  typedef logic [2:0] colour_t;
  localparam colour_t COL_WHITE = 3'd0;
  localparam colour_t COL_BLACK = 3'd1;
  localparam colour_t COL_BLUE = 3'd2;
  localparam colour_t COL_SHINY = 3'd3;
  localparam colour_t COL_UNKNOWN = 3'd4;
  localparam colour_t COL_NOT_UPDATED = 3'd5;

  localparam logic [IDX_W-1:0] REG_WHITE = 3'd0;
  localparam logic [IDX_W-1:0] REG_BLACK = 3'd1;
  localparam logic [IDX_W-1:0] REG_BLUE = 3'd2;
  localparam logic [IDX_W-1:0] REG_SHINY = 3'd3;
  localparam logic [IDX_W-1:0] REG_RADII = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX = 3'd5;

  localparam logic [REG_W-1:0] RADII_RESET = 64'd90071992547410400;
  localparam logic [REG_W-1:0] MAX_RESET = 64'd315256784300278560;

  typedef struct packed {
    logic       capture;
    logic       acc_clear;
    logic       acc_en;
    logic [1:0] chan;
    logic [1:0] scan;
    logic       root_load;
    logic       root_step;
    logic       pick;
    logic       override;
    logic       limit;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // References are scanned in tie-break order.
  function automatic colour_t scan_code(input logic [1:0] k);
    colour_t c;
    case (k)
      2'd0: c = COL_BLACK;
      2'd1: c = COL_BLUE;
      2'd2: c = COL_WHITE;
      default: c = COL_SHINY;
    endcase
    return c;
  endfunction

  function automatic logic [FIELD_W-1:0] field16(input logic [REG_W-1:0] w,
                                                 input logic [1:0] i);
    return w[FIELD_W*i +: FIELD_W];
  endfunction

endpackage

/* hw/rtl/nrcc_in_if.sv */
interface nrcc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_value;
  logic [15:0] green_value;
  logic [15:0] blue_value;
  logic [15:0] clear_value;
  logic        fresh;
  modport source(output valid, red_value, green_value, blue_value, clear_value, fresh,
                 input ready);
  modport sink(input valid, red_value, green_value, blue_value, clear_value, fresh,
               output ready);
endinterface

/* hw/rtl/nrcc_out_if.sv */
interface nrcc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] floor_code;
  logic [2:0] last_known_code;
  modport source(output valid, floor_code, last_known_code, input ready);
  modport sink(input valid, floor_code, last_known_code, output ready);
endinterface

/* hw/rtl/nrcc_ctrl.sv */
module nrcc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_fresh,
  output logic          in_ready,
  input  nrcc_pkg::stat_t stat,
  output nrcc_pkg::cmd_t  cmd
);
  import nrcc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_ACCUM    = 8'b0000_0010,
    S_RLOAD    = 8'b0000_0100,
    S_ROOT     = 8'b0000_1000,
    S_PICK     = 8'b0001_0000,
    S_OVERRIDE = 8'b0010_0000,
    S_LIMIT    = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic [1:0] chan, chan_next;
  logic [1:0] scan, scan_next;
  logic [STEP_W-1:0] step, step_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    chan_next = chan;
    scan_next = scan;
    step_next = step;
    cmd = '0;
    cmd.chan = chan;
    cmd.scan = scan;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.acc_clear = 1'b1;
          chan_next = 2'd0;
          scan_next = 2'd0;
          state_next = in_fresh ? S_ACCUM : S_FINISH;
        end
      end
      S_ACCUM: begin
        cmd.acc_en = 1'b1;
        chan_next = chan + 2'd1;
        if (chan == 2'd3) state_next = S_RLOAD;
      end
      S_RLOAD: begin
        cmd.root_load = 1'b1;
        step_next = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(ROOT_W - 1)) state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        cmd.acc_clear = 1'b1;
        scan_next = scan + 2'd1;
        state_next = (scan == 2'd3) ? S_OVERRIDE : S_ACCUM;
      end
      S_OVERRIDE: begin
        cmd.override = 1'b1;
        state_next = S_LIMIT;
      end
      S_LIMIT: begin
        cmd.limit = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chan <= '0;
      scan <= '0;
      step <= '0;
    end else begin
      state <= state_next;
      chan <= chan_next;
      scan <= scan_next;
      step <= step_next;
    end
  end

endmodule

/* hw/rtl/nrcc_datapath.sv */
module nrcc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [nrcc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [nrcc_pkg::REG_W-1:0]    cfg_data,
  input  logic [15:0]                   red_value,
  input  logic [15:0]                   green_value,
  input  logic [15:0]                   blue_value,
  input  logic [15:0]                   clear_value,
  input  nrcc_pkg::cmd_t                cmd,
  output nrcc_pkg::stat_t               stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [2:0]                    floor_code,
  output logic [2:0]                    last_known_code
);
  import nrcc_pkg::*;

  logic [REG_W-1:0] refs [4];
  logic [REG_W-1:0] radii, maxd;
  logic [CHANNEL_BITS-1:0] rd [4];
  logic [SUM_W-1:0] acc;
  logic [RAD_W-1:0] rad;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W-1:0] root;
  colour_t best_code, held, known;
  logic signed [ADJ_W-1:0] best_adj, white_adj;
  logic [MAG_W-1:0] best_dist, white_dist;

  colour_t cur_code;
  logic [CHANNEL_BITS-1:0] a, b, d;
  logic [2*CHANNEL_BITS-1:0] sq;
  logic [ROOT_W+1:0] rem_sh, trial;
  logic [MAG_W-1:0] dist_ext;
  logic signed [ADJ_W-1:0] adj;
  logic [MAG_W:0] limit_val;

  assign cur_code = scan_code(cmd.scan);
  assign a = rd[cmd.chan];
  assign b = CHANNEL_BITS'(field16(refs[cur_code[1:0]], cmd.chan));
  assign d = (a > b) ? a - b : b - a;
  assign sq = d * d;

  assign rem_sh = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
  assign trial = {root, 2'b01};

  assign dist_ext = MAG_W'(root);
  assign adj = $signed({1'b0, dist_ext})
             - $signed({1'b0, MAG_W'(field16(radii, cur_code[1:0]))});

  assign limit_val = (MAG_W + 1)'(field16(maxd, best_code[1:0]))
                   + (MAG_W + 1)'(field16(radii, best_code[1:0]));

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      refs[0] <= '0;
      refs[1] <= '0;
      refs[2] <= '0;
      refs[3] <= '0;
      radii <= RADII_RESET;
      maxd <= MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WHITE: refs[0] <= cfg_data;
        REG_BLACK: refs[1] <= cfg_data;
        REG_BLUE:  refs[2] <= cfg_data;
        REG_SHINY: refs[3] <= cfg_data;
        REG_RADII: radii <= cfg_data;
        REG_MAX:   maxd <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd[0] <= red_value[CHANNEL_BITS-1:0];
      rd[1] <= green_value[CHANNEL_BITS-1:0];
      rd[2] <= blue_value[CHANNEL_BITS-1:0];
      rd[3] <= clear_value[CHANNEL_BITS-1:0];
    end
    if (cmd.acc_clear) acc <= '0;
    else if (cmd.acc_en) acc <= acc + SUM_W'(sq);
    // One result bit per cycle: restoring square root over bit pairs.
    if (cmd.root_load) begin
      rad <= {acc, (2*FRAC_BITS)'(0)};
      rem <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
    // Strict compare keeps the earlier reference on ties.
    if (cmd.pick) begin
      if (cmd.scan == 2'd0 || adj < best_adj) begin
        best_adj <= adj;
        best_code <= cur_code;
        best_dist <= dist_ext;
      end
      if (cur_code == COL_WHITE) begin
        white_adj <= adj;
        white_dist <= dist_ext;
      end
    end
    if (cmd.override && best_code == COL_SHINY &&
        white_adj <= $signed({1'b0, MAG_W'(field16(maxd, 2'd0))})) begin
      best_code <= COL_WHITE;
      best_dist <= white_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= COL_NOT_UPDATED;
      known <= COL_NOT_UPDATED;
      out_valid <= 1'b0;
    end else begin
      if (cmd.limit) begin
        if ({1'b0, best_dist} <= limit_val) begin
          held <= best_code;
          known <= best_code;
        end else begin
          held <= COL_UNKNOWN;
        end
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      floor_code <= held;
      last_known_code <= known;
    end
  end

endmodule

/* hw/rtl/nearest_reference_colour_classifier_top.sv */
// Channel   Direction  Word
// in_ch     sink       red, green, blue, clear counts and fresh flag
// out_ch    source     floor_code, last_known_code
// cfg       write      cfg_we, cfg_index, cfg_data (six 64-bit registers)
//
// For a fresh word, each reference needs a multiply-accumulate for each of the four channels,
// a root load, one root step per result bit and a pick; then override, limit and emit follow.
// A word that is not fresh goes straight to emit. One word is in flight at a time.
// Reset is synchronous; a result waits in the output register while out_ch stalls.
module nearest_reference_colour_classifier_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [nrcc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [nrcc_pkg::REG_W-1:0]  cfg_data,
  nrcc_in_if.sink                     in_ch,
  nrcc_out_if.source                  out_ch
);
  import nrcc_pkg::*;

  cmd_t cmd;
  stat_t stat;
  logic in_ready;

  assign in_ch.ready = in_ready;

  nrcc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_ch.valid),
    .in_fresh(in_ch.fresh),
    .in_ready(in_ready),
    .stat(stat),
    .cmd(cmd)
  );

  nrcc_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .red_value(in_ch.red_value),
    .green_value(in_ch.green_value),
    .blue_value(in_ch.blue_value),
    .clear_value(in_ch.clear_value),
    .cmd(cmd),
    .stat(stat),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .floor_code(out_ch.floor_code),
    .last_known_code(out_ch.last_known_code)
  );

endmodule
